// ----- rtl/cbp_pkg.sv -----
// Shared types and constants for the coefficient bit pack/unpack block.
// No dependencies; every other file imports this package.
package cbp_pkg;

  // Payload widths of the channels.
  localparam int unsigned COEFF_W    = 18;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned FW_W       = 5;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_COEFFS_DEF = 1024;
  localparam int unsigned MAX_WIDTH_DEF  = 17;

  // Register reset values.
  localparam int unsigned WIDTH_RST = 17;
  localparam int unsigned COUNT_RST = 512;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION   = 2'd0,
    REG_FIELD_WIDTH = 2'd1,
    REG_SIGN_EXTEND = 2'd2,
    REG_COEFF_COUNT = 2'd3
  } cfg_reg_e;

  localparam logic DIR_PACK   = 1'b0;
  localparam logic DIR_UNPACK = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic cfg_we;
    logic load;
    logic step;
  } cbp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic have;
    logic last;
  } cbp_status_t;

endpackage

// ----- rtl/cbp_if.sv -----
// Valid/ready channel interfaces: coefficient/byte input, result output and
// configuration write. Depends on cbp_pkg.
interface cbp_in_if import cbp_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COEFF_W-1:0] coeff_in;
  logic        [BYTE_W-1:0]  byte_in;

  modport source (output valid, output coeff_in, output byte_in, input ready);
  modport sink   (input valid, input coeff_in, input byte_in, output ready);
endinterface

interface cbp_out_if import cbp_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic        [BYTE_W-1:0]  byte_out;
  logic signed [COEFF_W-1:0] coeff_out;
  logic                      run_last;
  logic                      poly_done;

  modport source (output valid, output byte_out, output coeff_out, output run_last,
                  output poly_done, input ready);
  modport sink   (input valid, input byte_out, input coeff_out, input run_last,
                  input poly_done, output ready);
endinterface

interface cbp_cfg_if import cbp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/cbp_datapath.sv -----
// Datapath: configuration registers, bit accumulator, counters and the
// result register. Depends on cbp_pkg.
module cbp_datapath import cbp_pkg::*; #(
  parameter int unsigned MaxCoeffs = MAX_COEFFS_DEF,
  parameter int unsigned MaxWidth  = MAX_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cbp_cmd_t                  cmd_i,
  output cbp_status_t               status_o,
  input  logic signed [COEFF_W-1:0] coeff_in_i,
  input  logic        [BYTE_W-1:0]  byte_in_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  output logic        [BYTE_W-1:0]  byte_out_o,
  output logic signed [COEFF_W-1:0] coeff_out_o,
  output logic                      run_last_o,
  output logic                      poly_done_o
);

  localparam int unsigned AccW   = MaxWidth + 7;
  localparam int unsigned HeldW  = $clog2(AccW + 1);
  localparam int unsigned CntW   = $clog2(MaxCoeffs + 1);
  localparam int unsigned DataW  = (AccW > COEFF_W) ? AccW : COEFF_W;
  localparam int unsigned WRst   = (WIDTH_RST > MaxWidth) ? MaxWidth : WIDTH_RST;
  localparam int unsigned CRst   = (COUNT_RST > MaxCoeffs) ? MaxCoeffs : COUNT_RST;

  logic              dir_q, dir_d;
  logic [FW_W-1:0]   width_q, width_d;
  logic              sext_q, sext_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [HeldW-1:0]  held_q, held_d;
  logic [CntW-1:0]   done_cnt_q, done_cnt_d;
  logic              end_q, end_d;

  logic [BYTE_W-1:0]         byte_q, byte_d;
  logic signed [COEFF_W-1:0] coeff_q, coeff_d;
  logic                      run_last_q, run_last_d;
  logic                      poly_done_q, poly_done_d;

  logic [HeldW-1:0] width_h, held_after, held_sub;
  logic [DataW-1:0] mask, sign_mask, field, coeff_ext, cin;
  logic [CntW-1:0]  cnt_inc;
  logic             cnt_end, held_ge8, pack_have, pack_next, un_have, un_last, fin;
  logic [AccW-1:0]  pack_ins, unpack_ins;
  logic [FW_W-1:0]  wr_width;
  logic [CFG_DATA_W-1:0] wr_count;

  always_comb begin
    width_h    = HeldW'(width_q);
    mask       = (DataW'(1) << width_q) - DataW'(1);
    sign_mask  = mask ^ (mask >> 1);
    field      = DataW'(acc_q) & mask;
    coeff_ext  = (sext_q && (|(field & sign_mask))) ? (field | ~mask) : field;
    cnt_inc    = done_cnt_q + CntW'(1);
    cnt_end    = (cnt_inc >= count_q);

    held_ge8   = (held_q >= HeldW'(8));
    held_after = held_ge8 ? (held_q - HeldW'(8)) : '0;
    pack_have  = held_ge8 || (end_q && (held_q != '0));
    pack_next  = (held_after >= HeldW'(8)) || (end_q && (held_after != '0));

    un_have    = (held_q >= width_h);
    held_sub   = held_q - width_h;
    un_last    = cnt_end || (held_sub < width_h);

    status_o.have = (dir_q == DIR_UNPACK) ? un_have : pack_have;
    status_o.last = (dir_q == DIR_UNPACK) ? un_last : !pack_next;
    fin           = (dir_q == DIR_UNPACK) ? cnt_end : (end_q && !pack_next);

    cin        = DataW'($unsigned(coeff_in_i));
    pack_ins   = AccW'(cin & mask) << held_q[2:0];
    unpack_ins = AccW'(byte_in_i) << held_q;

    // Clamp register writes into their legal ranges.
    wr_width = cfg_data_i[FW_W-1:0];
    if (wr_width == '0) begin
      wr_width = FW_W'(1);
    end else if (32'(wr_width) > MaxWidth) begin
      wr_width = FW_W'(MaxWidth);
    end
    wr_count = cfg_data_i;
    if (wr_count == '0) begin
      wr_count = CFG_DATA_W'(1);
    end else if (32'(wr_count) > MaxCoeffs) begin
      wr_count = CFG_DATA_W'(MaxCoeffs);
    end
  end

  always_comb begin
    dir_d       = dir_q;
    width_d     = width_q;
    sext_d      = sext_q;
    count_d     = count_q;
    acc_d       = acc_q;
    held_d      = held_q;
    done_cnt_d  = done_cnt_q;
    end_d       = end_q;
    byte_d      = byte_q;
    coeff_d     = coeff_q;
    run_last_d  = run_last_q;
    poly_done_d = poly_done_q;

    priority if (cmd_i.cfg_we) begin
      acc_d      = '0;
      held_d     = '0;
      done_cnt_d = '0;
      end_d      = 1'b0;
      unique case (cfg_reg_e'(cfg_index_i))
        REG_DIRECTION:   dir_d   = cfg_data_i[0];
        REG_FIELD_WIDTH: width_d = wr_width;
        REG_SIGN_EXTEND: sext_d  = cfg_data_i[0];
        REG_COEFF_COUNT: count_d = CntW'(wr_count);
      endcase
    end else if (cmd_i.load) begin
      if (dir_q == DIR_PACK) begin
        acc_d      = acc_q | pack_ins;
        held_d     = held_q + width_h;
        done_cnt_d = cnt_inc;
        end_d      = cnt_end;
      end else begin
        acc_d  = acc_q | unpack_ins;
        held_d = held_q + HeldW'(8);
      end
    end else if (cmd_i.step) begin
      byte_d      = (dir_q == DIR_PACK) ? acc_q[BYTE_W-1:0] : '0;
      coeff_d     = (dir_q == DIR_UNPACK) ? COEFF_W'(coeff_ext) : '0;
      run_last_d  = status_o.last;
      poly_done_d = fin;
      if (fin) begin
        acc_d      = '0;
        held_d     = '0;
        done_cnt_d = '0;
        end_d      = 1'b0;
      end else if (dir_q == DIR_UNPACK) begin
        acc_d      = acc_q >> width_q;
        held_d     = held_sub;
        done_cnt_d = cnt_inc;
      end else begin
        acc_d  = acc_q >> BYTE_W;
        held_d = held_after;
      end
    end else begin
      // Hold every register.
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= DIR_PACK;
      width_q    <= FW_W'(WRst);
      sext_q     <= 1'b0;
      count_q    <= CntW'(CRst);
      acc_q      <= '0;
      held_q     <= '0;
      done_cnt_q <= '0;
      end_q      <= 1'b0;
    end else begin
      dir_q      <= dir_d;
      width_q    <= width_d;
      sext_q     <= sext_d;
      count_q    <= count_d;
      acc_q      <= acc_d;
      held_q     <= held_d;
      done_cnt_q <= done_cnt_d;
      end_q      <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    coeff_q     <= coeff_d;
    run_last_q  <= run_last_d;
    poly_done_q <= poly_done_d;
  end

  assign byte_out_o  = byte_q;
  assign coeff_out_o = coeff_q;
  assign run_last_o  = run_last_q;
  assign poly_done_o = poly_done_q;

endmodule

// ----- rtl/cbp_ctrl.sv -----
// Controller: accept/emit state machine and the result valid flag.
// Depends on cbp_pkg.
module cbp_ctrl import cbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  cbp_status_t status_i,
  output cbp_cmd_t    cmd_o
);

  typedef enum logic {S_IDLE, S_EMIT} state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   idle, out_free;

  always_comb begin
    idle         = (state_q == S_IDLE);
    out_free     = !out_valid_q || out_ready_i;
    cfg_ready_o  = idle;
    in_ready_o   = idle && !cfg_valid_i;
    cmd_o.cfg_we = cfg_valid_i && idle;
    cmd_o.load   = in_valid_i && in_ready_o;
    cmd_o.step   = !idle && status_i.have && out_free;

    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (cmd_o.load) state_d = S_EMIT;
      S_EMIT: begin
        // Drop back to idle when nothing is left or the last result leaves.
        if (!status_i.have || (cmd_o.step && status_i.last)) state_d = S_IDLE;
      end
    endcase

    out_valid_d = cmd_o.step ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/coefficient_bit_pack_unpack.sv -----
// Coefficient bit pack/unpack, top level: controller plus datapath.
// An item is taken, then its results (0..3 packing, 0..8 unpacking) leave the
// single result register one per cycle while the output is not stalled. Accept
// moves the controller to S_EMIT, where each step loads that register and raises
// result valid. rst_ni (async, active low) clears the stream state and loads
// register defaults: pack, width 17, no sign extension, 512 coefficients.
module coefficient_bit_pack_unpack import cbp_pkg::*; #(
  parameter int unsigned MaxCoeffs = MAX_COEFFS_DEF,
  parameter int unsigned MaxWidth  = MAX_WIDTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  cbp_in_if.sink   in_if_i,
  cbp_out_if.source out_if_o,
  cbp_cfg_if.sink  cfg_if_i
);

  cbp_cmd_t    cmd;
  cbp_status_t status;

  // Controller: decides when a request is taken and when a result is pushed.
  cbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if_i.valid),
    .in_ready_o  (in_if_i.ready),
    .cfg_valid_i (cfg_if_i.valid),
    .cfg_ready_o (cfg_if_i.ready),
    .out_valid_o (out_if_o.valid),
    .out_ready_i (out_if_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: holds the accumulator and produces one byte or field per step.
  cbp_datapath #(
    .MaxCoeffs (MaxCoeffs),
    .MaxWidth  (MaxWidth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .coeff_in_i  (in_if_i.coeff_in),
    .byte_in_i   (in_if_i.byte_in),
    .cfg_index_i (cfg_if_i.index),
    .cfg_data_i  (cfg_if_i.data),
    .byte_out_o  (out_if_o.byte_out),
    .coeff_out_o (out_if_o.coeff_out),
    .run_last_o  (out_if_o.run_last),
    .poly_done_o (out_if_o.poly_done)
  );

endmodule

// ----- rtl/cbp_checker.sv -----
// Port-level checks for coefficient_bit_pack_unpack, bound to the top level.
// Depends on cbp_pkg.
module cbp_checker import cbp_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic        [BYTE_W-1:0]  byte_out_i,
  input logic signed [COEFF_W-1:0] coeff_out_i,
  input logic                      run_last_i,
  input logic                      poly_done_i
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_out_i)
      && $stable(coeff_out_i) && $stable(run_last_i) && $stable(poly_done_i))
    else $error("stalled result changed");

  // The polynomial's final result always closes its request.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && poly_done_i |-> run_last_i)
    else $error("poly_done without run_last");

  // One request at a time: no new request right after one is taken.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

  // Results only follow a request: a fresh result is produced in a busy cycle.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while idle");

endmodule

bind coefficient_bit_pack_unpack cbp_checker u_cbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if_i.valid),
  .in_ready_i  (in_if_i.ready),
  .out_valid_i (out_if_o.valid),
  .out_ready_i (out_if_o.ready),
  .byte_out_i  (out_if_o.byte_out),
  .coeff_out_i (out_if_o.coeff_out),
  .run_last_i  (out_if_o.run_last),
  .poly_done_i (out_if_o.poly_done)
);
